[rtl/cle_pkg.sv]
// shared codes and widths for the console line editor
// used by text_console_line_editor_core and cle_row_div; no dependencies
package cle_pkg;

   localparam int CURSOR_W = 16;
   localparam int CHAR_W   = 8;
   localparam int LEN_W    = 6;

   // operation codes of the request channel
   localparam logic [1:0] OP_PRINT   = 2'd0;
   localparam logic [1:0] OP_NEWLINE = 2'd1;
   localparam logic [1:0] OP_KEY     = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CELL = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // keystroke codes
   localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] KEY_LF        = 8'd10;
   localparam logic [CHAR_W-1:0] KEY_CR        = 8'd13;
   localparam logic [CHAR_W-1:0] BLANK_CHAR    = 8'd32;

   localparam logic [7:0] ATTR_RESET = 8'h07;

endpackage

[rtl/cle_row_div.sv]
// next-row-start computation for a newline: cursor rounded down to a row, plus one row
// reciprocal multiply with one correction step, two register stages; uses cle_pkg
module cle_row_div import cle_pkg::*; #(
   parameter int ROW_BYTES = 160
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CURSOR_W-1:0] cursor,
   output logic                done,
   output logic [CURSOR_W-1:0] next_row
);

   localparam int SHIFT  = CURSOR_W + $clog2(ROW_BYTES);
   localparam int PROD_W = CURSOR_W + SHIFT;
   localparam logic [SHIFT-1:0]    RECIP = SHIFT'((64'd1 << SHIFT) / ROW_BYTES);
   localparam logic [CURSOR_W-1:0] ROW_C = CURSOR_W'(ROW_BYTES);

   logic [1:0]            stage_ff;
   logic [1:0]            stage_in;
   logic [CURSOR_W-1:0]   cur_ff;
   logic [CURSOR_W-1:0]   quot_ff;
   logic [CURSOR_W-1:0]   base_ff;
   logic [PROD_W-1:0]     prod;
   logic [2*CURSOR_W-1:0] base_full;
   logic [CURSOR_W-1:0]   rem;
   logic [CURSOR_W-1:0]   rem_fix;

   // quotient estimate is exact or one low
   assign prod      = PROD_W'(cursor) * PROD_W'(RECIP);
   assign base_full = (2*CURSOR_W)'(quot_ff) * (2*CURSOR_W)'(ROW_C);

   assign rem      = cur_ff - base_ff;
   assign rem_fix  = (rem >= ROW_C) ? (rem - ROW_C) : rem;
   assign next_row = cur_ff - rem_fix + ROW_C;
   assign done     = stage_ff[1];

   assign stage_in = {stage_ff[0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cur_ff  <= cursor;
         quot_ff <= prod[SHIFT +: CURSOR_W];
      end
      if (stage_ff[0]) begin
         base_ff <= base_full[CURSOR_W-1:0];
      end
   end

endmodule

[rtl/text_console_line_editor_core.sv]
// top level of the text console with one-line input editor
// holds the control sequencer, the line store memory and the csr; uses cle_pkg, cle_row_div
//
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  operation, key_char
// rsp       out        rsp_valid / rsp_ready  kind, cell_address, char_value, attribute,
//                                             line_length, last
// csr       in/out     apb, pready tied high  text_attribute at byte address 0
//
// one item in flight; a print, echo or erase sends one cell, a newline runs the two stages of
// the row divider, an enter reads ahead and sends each character then an end marker, only the
// marker on an empty line; ignored items (unused operation, full or empty line) send nothing
// reset clears cursor, fill count, sequencer and output valid; the line store is not cleared
// a stalled rsp holds the output register and the sequencer waits on it; a new request is
// taken as soon as the last result sits in the output register
module text_console_line_editor_core import cle_pkg::*; #(
   parameter int LINE_CAPACITY = 63,
   parameter int ROW_BYTES     = 160
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [CHAR_W-1:0]   req_key_char,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [CURSOR_W-1:0] rsp_cell_address,
   output logic [CHAR_W-1:0]   rsp_char_value,
   output logic [7:0]          rsp_attribute,
   output logic [LEN_W-1:0]    rsp_line_length,
   output logic                rsp_last,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int FILL_W = $clog2(LINE_CAPACITY + 1);
   localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam logic [FILL_W-1:0] CAP_C = FILL_W'(LINE_CAPACITY);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CELL  = 3'd1;
   localparam logic [2:0] ST_ROW   = 3'd2;
   localparam logic [2:0] ST_LREAD = 3'd3;
   localparam logic [2:0] ST_LEMIT = 3'd4;
   localparam logic [2:0] ST_LEND  = 3'd5;

   // what a pending cell write does
   localparam logic [1:0] MODE_PRINT = 2'd0;
   localparam logic [1:0] MODE_STORE = 2'd1;
   localparam logic [1:0] MODE_ERASE = 2'd2;

   logic [2:0]          state_ff, state_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   idx_ff, idx_in;
   logic [1:0]          mode_ff, mode_in;
   logic [CHAR_W-1:0]   key_ff, key_in;
   logic [7:0]          attr_ff;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_kind_ff;
   logic [CURSOR_W-1:0] rsp_addr_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [7:0]          rsp_attr_ff;
   logic [LEN_W-1:0]    rsp_len_ff;
   logic                rsp_last_ff;

   logic                accept;
   logic                slot_free;
   logic                load;
   logic [1:0]          o_kind;
   logic [CURSOR_W-1:0] o_addr;
   logic [CHAR_W-1:0]   o_char;
   logic [7:0]          o_attr;
   logic [LEN_W-1:0]    o_len;
   logic                o_last;

   logic                wr_en;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [CHAR_W-1:0]   rd_data_ff;
   logic [CHAR_W-1:0]   line_mem [LINE_CAPACITY];

   logic                div_start;
   logic                div_done;
   logic [CURSOR_W-1:0] div_next;

   logic                csr_wr;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready & ~csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {24'd0, attr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_wr) begin
         attr_ff <= csr_pwdata[7:0];
      end
   end

   // ---------------------------------------------------------------- row divider
   cle_row_div #(
      .ROW_BYTES (ROW_BYTES)
   ) u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .cursor   (cursor_ff),
      .done     (div_done),
      .next_row (div_next)
   );

   // ---------------------------------------------------------------- sequencer
   // only one item is in flight, so a store write and a read of the line never overlap
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   // output register can take a new result when empty or being drained this cycle
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      mode_in   = mode_ff;
      key_in    = key_ff;
      load      = 1'b0;
      o_kind    = KIND_CELL;
      o_addr    = '0;
      o_char    = '0;
      o_attr    = '0;
      o_len     = '0;
      o_last    = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[ADDR_W-1:0];
      div_start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_key_char;
               case (req_operation)
                  OP_PRINT: begin
                     mode_in  = MODE_PRINT;
                     state_in = ST_CELL;
                  end
                  OP_NEWLINE: begin
                     div_start = 1'b1;
                     state_in  = ST_ROW;
                  end
                  OP_KEY: begin
                     if (req_key_char inside {KEY_CR, KEY_LF}) begin
                        // enter: read the line out, or go straight to the end marker
                        idx_in   = '0;
                        state_in = (fill_ff == '0) ? ST_LEND : ST_LREAD;
                     end else if (req_key_char == KEY_BACKSPACE) begin
                        if (fill_ff != '0) begin
                           mode_in  = MODE_ERASE;
                           state_in = ST_CELL;
                        end
                     end else if (fill_ff < CAP_C) begin
                        mode_in  = MODE_STORE;
                        state_in = ST_CELL;
                     end
                  end
                  default: begin
                     // unused operation: dropped
                  end
               endcase
            end
         end

         ST_CELL: begin
            if (slot_free) begin
               load     = 1'b1;
               o_kind   = KIND_CELL;
               o_attr   = attr_ff;
               o_last   = 1'b1;
               state_in = ST_IDLE;
               if (mode_ff == MODE_ERASE) begin
                  // blank the previous cell and leave the cursor on it
                  o_addr    = cursor_ff - CURSOR_W'(2);
                  o_char    = BLANK_CHAR;
                  cursor_in = cursor_ff - CURSOR_W'(2);
                  fill_in   = fill_ff - FILL_W'(1);
               end else begin
                  o_addr    = cursor_ff;
                  o_char    = key_ff;
                  cursor_in = cursor_ff + CURSOR_W'(2);
                  if (mode_ff == MODE_STORE) begin
                     wr_en   = 1'b1;
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
         end

         ST_ROW: begin
            if (div_done) begin
               cursor_in = div_next;
               state_in  = ST_IDLE;
            end
         end

         ST_LREAD: begin
            rd_en    = 1'b1;
            state_in = ST_LEMIT;
         end

         ST_LEMIT: begin
            // read data holds while stalled; next read issues with each transfer but the last
            if (slot_free) begin
               load   = 1'b1;
               o_kind = KIND_LINE;
               o_char = rd_data_ff;
               idx_in = idx_ff + FILL_W'(1);
               if (idx_in == fill_ff) begin
                  state_in = ST_LEND;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_in[ADDR_W-1:0];
               end
            end
         end

         ST_LEND: begin
            if (slot_free) begin
               load     = 1'b1;
               o_kind   = KIND_END;
               o_len    = LEN_W'(fill_ff);
               o_last   = 1'b1;
               fill_in  = '0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cursor_ff <= '0;
         fill_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      mode_ff <= mode_in;
      key_ff  <= key_in;
   end

   // ---------------------------------------------------------------- line store
   // written at the fill position, read ahead of each line transfer into registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[fill_ff[ADDR_W-1:0]] <= key_ff;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff <= o_kind;
         rsp_addr_ff <= o_addr;
         rsp_char_ff <= o_char;
         rsp_attr_ff <= o_attr;
         rsp_len_ff  <= o_len;
         rsp_last_ff <= o_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_cell_address = rsp_addr_ff;
   assign rsp_char_value   = rsp_char_ff;
   assign rsp_attribute    = rsp_attr_ff;
   assign rsp_line_length  = rsp_len_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   // the fill count never passes the line capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_C)
      else $error("line fill count above capacity");

   // a new result never overwrites one still waiting in the output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (~rsp_valid_ff | rsp_ready))
      else $error("output register overwritten");

   // the line store is never written and read in the same cycle
   a_mem_excl: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("line store write and read overlap");

   // line readout stays below the fill count
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEMIT) |-> (idx_ff < fill_ff))
      else $error("line readout past fill count");

   // the end marker empties the line
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEND && load) |=> (fill_ff == '0 && state_ff == ST_IDLE))
      else $error("line not emptied after end marker");

endmodule
